// ----- rtl/core/frpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frpf_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 16;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned ACTION_W   = 8;
  localparam int unsigned HOP_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IDX_OUT_W  = 4;
  localparam int unsigned RULES_W    = 5;
  localparam int unsigned CNT_W      = 32;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 168;

  localparam logic [TYPE_W-1:0] TYPE_DATA   = 8'h01;
  localparam logic [TYPE_W-1:0] TYPE_CONFIG = 8'h10;
  localparam logic [TYPE_W-1:0] TYPE_RULE   = 8'h12;

  localparam logic [LEN_W-1:0] MIN_LEN      = 16'd7;
  localparam logic [LEN_W-1:0] MIN_RULE_LEN = 16'd14;

  typedef enum logic [STATUS_W-1:0] {
    STAT_TOO_SHORT  = 3'd0,
    STAT_RULE_ADDED = 3'd1,
    STAT_TABLE_FULL = 3'd2,
    STAT_RULE_SHORT = 3'd3,
    STAT_FORWARDED  = 3'd4,
    STAT_DROPPED    = 3'd5,
    STAT_CONFIG     = 3'd6,
    STAT_UNKNOWN    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]    hits;
    logic [HOP_W-1:0]    hop;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   dst;
    logic [ADDR_W-1:0]   src;
  } entry_t;

  typedef struct packed {
    logic load;
    logic start_scan;
    logic scan;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_req;
    logic match;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/frpf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frpf_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  frpf_pkg::dp_status_t dp_status_i,
  output frpf_pkg::ctrl_cmd_t  cmd_o
);

  frpf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frpf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = frpf_pkg::ST_CLASSIFY;
        end
      end
      frpf_pkg::ST_CLASSIFY: begin
        if (dp_status_i.scan_req) begin
          state_d = frpf_pkg::ST_SCAN;
        end else begin
          state_d = frpf_pkg::ST_DONE;
        end
      end
      frpf_pkg::ST_SCAN: begin
        if (dp_status_i.match || dp_status_i.last) begin
          state_d = frpf_pkg::ST_DONE;
        end
      end
      frpf_pkg::ST_DONE: begin
        if (dp_status_i.out_free) begin
          state_d = frpf_pkg::ST_IDLE;
        end
      end
      default: state_d = frpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      frpf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      frpf_pkg::ST_CLASSIFY: begin
        cmd_o.start_scan = dp_status_i.scan_req;
      end
      frpf_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.step = !dp_status_i.match && !dp_status_i.last;
      end
      frpf_pkg::ST_DONE: begin
        cmd_o.commit = dp_status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/frpf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frpf_dp #(
  parameter int unsigned TABLE_DEPTH = frpf_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire  [frpf_pkg::IN_TDATA_W-1:0]        in_data_i,
  input  wire  [frpf_pkg::TYPE_W-1:0]            in_type_i,
  input  frpf_pkg::ctrl_cmd_t                    cmd_i,
  output frpf_pkg::dp_status_t                   status_o,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic [frpf_pkg::OUT_TDATA_W-1:0]       out_data_o,
  output logic [frpf_pkg::STATUS_W-1:0]          out_status_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic [frpf_pkg::LEN_W-1:0]    len_q;
  logic [frpf_pkg::TYPE_W-1:0]   type_q;
  logic [frpf_pkg::ADDR_W-1:0]   dst_q;
  logic [frpf_pkg::ADDR_W-1:0]   src_q;
  logic [frpf_pkg::ACTION_W-1:0] act_q;
  logic [frpf_pkg::HOP_W-1:0]    hop_q;

  logic [IdxW-1:0] scan_q, scan_d;
  logic            hit_q, hit_d;
  logic [CntW-1:0] count_q, count_d;
  logic [frpf_pkg::CNT_W-1:0] rx_q, rx_d, fwd_q, fwd_d, drop_q, drop_d;

  frpf_pkg::entry_t mem [TABLE_DEPTH];
  frpf_pkg::entry_t rdata_q;
  frpf_pkg::entry_t wr_data;
  logic [IdxW-1:0]  wr_addr;
  logic             wr_en;

  logic len_ok, is_rule, is_data, table_full, match;
  logic [frpf_pkg::CNT_W-1:0] hits_inc;

  frpf_pkg::status_e            res_status;
  logic [frpf_pkg::HOP_W-1:0]   res_hop;
  logic [frpf_pkg::ACTION_W-1:0] res_act;
  logic [frpf_pkg::IDX_OUT_W-1:0] res_idx;
  logic [frpf_pkg::CNT_W-1:0]   res_hits;

  logic out_valid_q, out_valid_d;
  logic [frpf_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [frpf_pkg::STATUS_W-1:0]    out_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q  <= in_data_i[15:0];
      dst_q  <= in_data_i[31:16];
      src_q  <= in_data_i[47:32];
      act_q  <= in_data_i[55:48];
      hop_q  <= in_data_i[71:56];
      type_q <= in_type_i;
    end
  end

  assign len_ok     = (len_q >= frpf_pkg::MIN_LEN);
  assign is_rule    = (type_q == frpf_pkg::TYPE_RULE);
  assign is_data    = (type_q == frpf_pkg::TYPE_DATA);
  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign match      = (rdata_q.src == src_q) && (rdata_q.dst == dst_q);
  assign hits_inc   = rdata_q.hits + 32'd1;

  assign status_o.scan_req = len_ok && is_data && (count_q != '0);
  assign status_o.match    = match;
  assign status_o.last     = ((CntW'(scan_q) + CntW'(1)) == count_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.start_scan) begin
      scan_d = '0;
    end else if (cmd_i.step) begin
      scan_d = scan_q + IdxW'(1);
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (cmd_i.load) begin
      hit_d = 1'b0;
    end else if (cmd_i.scan && match) begin
      hit_d = 1'b1;
    end
  end

  always_comb begin
    res_status = frpf_pkg::STAT_TOO_SHORT;
    res_hop    = '0;
    res_act    = '0;
    res_idx    = '0;
    res_hits   = '0;
    count_d    = count_q;
    rx_d       = rx_q;
    fwd_d      = fwd_q;
    drop_d     = drop_q;
    wr_en      = 1'b0;
    wr_addr    = scan_q;
    wr_data    = rdata_q;
    if (len_ok) begin
      rx_d = rx_q + 32'd1;
      if (is_rule) begin
        if (len_q < frpf_pkg::MIN_RULE_LEN) begin
          res_status = frpf_pkg::STAT_RULE_SHORT;
        end else if (table_full) begin
          res_status = frpf_pkg::STAT_TABLE_FULL;
        end else begin
          res_status     = frpf_pkg::STAT_RULE_ADDED;
          res_idx        = frpf_pkg::IDX_OUT_W'(count_q);
          wr_en          = 1'b1;
          wr_addr        = IdxW'(count_q);
          wr_data.src    = src_q;
          wr_data.dst    = dst_q;
          wr_data.action = act_q;
          wr_data.hop    = hop_q;
          wr_data.hits   = '0;
          count_d        = count_q + CntW'(1);
        end
      end else if (is_data) begin
        if (hit_q) begin
          res_status   = frpf_pkg::STAT_FORWARDED;
          res_hop      = rdata_q.hop;
          res_act      = rdata_q.action;
          res_idx      = frpf_pkg::IDX_OUT_W'(scan_q);
          res_hits     = hits_inc;
          wr_en        = 1'b1;
          wr_data.hits = hits_inc;
          fwd_d        = fwd_q + 32'd1;
        end else begin
          res_status = frpf_pkg::STAT_DROPPED;
          drop_d     = drop_q + 32'd1;
        end
      end else if (type_q == frpf_pkg::TYPE_CONFIG) begin
        res_status = frpf_pkg::STAT_CONFIG;
      end else begin
        res_status = frpf_pkg::STAT_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[scan_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      hit_q       <= 1'b0;
      count_q     <= '0;
      rx_q        <= '0;
      fwd_q       <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        count_q <= count_d;
        rx_q    <= rx_d;
        fwd_q   <= fwd_d;
        drop_q  <= drop_d;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_data_q   <= {7'd0, drop_d, fwd_d, rx_d, frpf_pkg::RULES_W'(count_d),
                       res_hits, res_idx, res_act, res_hop};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/core/flow_rule_packet_forwarder.sv -----
// Exact-match flow table packet forwarder.
// The slave stream carries one parsed packet header per transfer; the
// packet type travels on tuser and the remaining header fields on tdata.
// The master stream returns one result per header: the status code on
// tuser, and on tdata the matched rule's next hop, action, index and hit
// count together with the rule count and the three packet counters.
// One header is processed at a time. Its fields are registered on transfer,
// then classified; a valid data packet with a nonempty table then compares
// the table entries in order until a match or the last entry. The result is
// written to the output register once that register is free, and the next
// header is taken after that; the entry scan reads the rule memory at one
// entry per cycle.
// The output register frees the input side: a new header is taken while a
// result still waits, and a header only stalls in its last cycle when the
// receiver has not yet taken the previous result.
// Reset empties the rule table and clears all counters and the output
// valid; the rule memory itself is not cleared, since only entries below
// the rule count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module flow_rule_packet_forwarder #(
  parameter int unsigned TABLE_DEPTH = frpf_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // length, dest_addr, source_addr, new_action, new_next_hop
  input  wire  [frpf_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // pkt_type
  input  wire  [frpf_pkg::TYPE_W-1:0]         s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // hop_out, action_out, match_index, match_hits, rules_in_use,
  // received_total, forwarded_total, dropped_total, zero fill
  output logic [frpf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // status
  output logic [frpf_pkg::STATUS_W-1:0]       m_axis_tuser_o
);

  frpf_pkg::ctrl_cmd_t  cmd;
  frpf_pkg::dp_status_t dp_status;

  frpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  frpf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata_i),
    .in_type_i    (s_axis_tuser_i),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- test/frpf_checker.sv -----
`timescale 1ns / 1ps

module frpf_checker
  import frpf_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_tvalid_i,
  input  wire                     s_tready_i,
  // length, dest_addr, source_addr, new_action, new_next_hop
  input  wire  [IN_TDATA_W-1:0]   s_tdata_i,
  // pkt_type
  input  wire  [TYPE_W-1:0]       s_tuser_i,
  input  wire                     m_tvalid_i,
  input  wire                     m_tready_i,
  // hop_out, action_out, match_index, match_hits, rules_in_use,
  // received_total, forwarded_total, dropped_total, zero fill
  input  wire  [OUT_TDATA_W-1:0]  m_tdata_i,
  // status
  input  wire  [STATUS_W-1:0]     m_tuser_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  localparam int unsigned DEPTH = DEFAULT_TABLE_DEPTH;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [HOP_W-1:0]     hop;
    logic [ACTION_W-1:0]  action;
    logic [IDX_OUT_W-1:0] index;
    logic [CNT_W-1:0]     hits;
    logic [RULES_W-1:0]   rules;
    logic [CNT_W-1:0]     received;
    logic [CNT_W-1:0]     forwarded;
    logic [CNT_W-1:0]     dropped;
  } fwd_result_t;

  logic [ADDR_W-1:0]   rule_src[DEPTH];
  logic [ADDR_W-1:0]   rule_dst[DEPTH];
  logic [ACTION_W-1:0] rule_action[DEPTH];
  logic [HOP_W-1:0]    rule_hop[DEPTH];
  logic [CNT_W-1:0]    rule_hits[DEPTH];
  int                  rule_count = 0;
  logic [CNT_W-1:0]    rx_total = '0;
  logic [CNT_W-1:0]    fwd_total = '0;
  logic [CNT_W-1:0]    drop_total = '0;
  int                  mismatch_count = 0;
  int                  pending = 0;

  fwd_result_t expected_results_q[$];

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending;

  function automatic fwd_result_t predict_forwarding(input logic [IN_TDATA_W-1:0] hdr,
                                                     input logic [TYPE_W-1:0] kind);
    fwd_result_t       res;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    int                hit;
    len = hdr[15:0];
    dst = hdr[31:16];
    src = hdr[47:32];
    res.status = STAT_TOO_SHORT;
    res.hop = '0;
    res.action = '0;
    res.index = '0;
    res.hits = '0;
    if (len >= MIN_LEN) begin
      rx_total = rx_total + 1'b1;
      if (kind == TYPE_RULE) begin
        if (len < MIN_RULE_LEN) begin
          res.status = STAT_RULE_SHORT;
        end else if (rule_count >= DEPTH) begin
          res.status = STAT_TABLE_FULL;
        end else begin
          rule_src[rule_count] = src;
          rule_dst[rule_count] = dst;
          rule_action[rule_count] = hdr[55:48];
          rule_hop[rule_count] = hdr[71:56];
          rule_hits[rule_count] = '0;
          res.index = rule_count[IDX_OUT_W-1:0];
          rule_count++;
          res.status = STAT_RULE_ADDED;
        end
      end else if (kind == TYPE_DATA) begin
        hit = -1;
        for (int i = 0; i < rule_count; i++) begin
          if (hit < 0 && rule_src[i] == src && rule_dst[i] == dst) hit = i;
        end
        if (hit >= 0) begin
          rule_hits[hit] = rule_hits[hit] + 1'b1;
          fwd_total = fwd_total + 1'b1;
          res.index = hit[IDX_OUT_W-1:0];
          res.hits = rule_hits[hit];
          res.hop = rule_hop[hit];
          res.action = rule_action[hit];
          res.status = STAT_FORWARDED;
        end else begin
          drop_total = drop_total + 1'b1;
          res.status = STAT_DROPPED;
        end
      end else if (kind == TYPE_CONFIG) begin
        res.status = STAT_CONFIG;
      end else begin
        res.status = STAT_UNKNOWN;
      end
    end
    res.rules = rule_count[RULES_W-1:0];
    res.received = rx_total;
    res.forwarded = fwd_total;
    res.dropped = drop_total;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] expv,
                             input logic [CNT_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    fwd_result_t exp_res;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result transfer with no header outstanding, status 0x%0h", m_tuser_i);
          mismatch_count++;
        end else begin
          exp_res = expected_results_q.pop_front();
          check_field("status", exp_res.status, m_tuser_i);
          check_field("hop_out", exp_res.hop, m_tdata_i[15:0]);
          check_field("action_out", exp_res.action, m_tdata_i[23:16]);
          check_field("match_index", exp_res.index, m_tdata_i[27:24]);
          check_field("match_hits", exp_res.hits, m_tdata_i[59:28]);
          check_field("rules_in_use", exp_res.rules, m_tdata_i[64:60]);
          check_field("received_total", exp_res.received, m_tdata_i[96:65]);
          check_field("forwarded_total", exp_res.forwarded, m_tdata_i[128:97]);
          check_field("dropped_total", exp_res.dropped, m_tdata_i[160:129]);
          check_field("zero_fill", '0, m_tdata_i[OUT_TDATA_W-1:161]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_results_q.push_back(predict_forwarding(s_tdata_i, s_tuser_i));
      end
      pending = expected_results_q.size();
    end
  end

endmodule

// ----- test/flow_rule_packet_forwarder_tb.sv -----
`timescale 1ns / 1ps

module flow_rule_packet_forwarder_tb;
  import frpf_pkg::*;

  localparam int RANDOM_PER_PHASE = 317;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [TYPE_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  int                     mismatches;
  int                     outstanding;
  int                     send_idle_pct = 38;
  int                     recv_idle_pct = 84;
  logic [ADDR_W-1:0]      known_src[$];
  logic [ADDR_W-1:0]      known_dst[$];

  always #5 clk_i = ~clk_i;

  flow_rule_packet_forwarder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  frpf_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tuser_i       (m_tuser),
    .mismatch_count_o(mismatches),
    .pending_o       (outstanding)
  );

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_header(input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] kind,
                             input logic [ADDR_W-1:0] dst, input logic [ADDR_W-1:0] src,
                             input logic [ACTION_W-1:0] act, input logic [HOP_W-1:0] hop);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {hop, act, src, dst, len};
    s_tuser <= kind;
    if (kind == TYPE_RULE) begin
      known_src.push_back(src);
      known_dst.push_back(dst);
    end
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 6) return LEN_W'($urandom_range(MIN_LEN - 1));
    if (r < 14) return LEN_W'($urandom_range(MIN_RULE_LEN - 1, MIN_LEN));
    if (r < 18) return '1;
    if (r < 50) return LEN_W'($urandom_range(64, MIN_RULE_LEN));
    return LEN_W'($urandom_range(16'hFFFF, MIN_RULE_LEN));
  endfunction

  task automatic send_random_header();
    int                r;
    int                pick;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic [TYPE_W-1:0] kind;
    r = $urandom_range(99);
    pick = $urandom_range(known_src.size() - 1);
    dst = known_dst[pick];
    src = known_src[pick];
    if (r < 8) begin
      send_header(LEN_W'($urandom), TYPE_W'($urandom), ADDR_W'($urandom),
                  ADDR_W'($urandom), ACTION_W'($urandom), HOP_W'($urandom));
    end else if (r < 30) begin
      if ($urandom_range(1)) begin
        dst = ADDR_W'($urandom);
        src = ADDR_W'($urandom);
      end
      send_header(pick_length(), TYPE_RULE, dst, src, ACTION_W'($urandom), HOP_W'($urandom));
    end else if (r < 38) begin
      kind = $urandom_range(1) ? TYPE_CONFIG : TYPE_TYPE_FILL();
      send_header(pick_length(), kind, ADDR_W'($urandom), ADDR_W'($urandom),
                  ACTION_W'($urandom), HOP_W'($urandom));
    end else begin
      r = $urandom_range(99);
      if (r < 10) begin
        dst = ADDR_W'($urandom);
        src = ADDR_W'($urandom);
      end else if (r < 20) begin
        src = known_src[$urandom_range(known_src.size() - 1)];
      end
      send_header(pick_length(), TYPE_DATA, dst, src, ACTION_W'($urandom), HOP_W'($urandom));
    end
  endtask

  function automatic logic [TYPE_W-1:0] TYPE_TYPE_FILL();
    logic [TYPE_W-1:0] kind;
    do kind = TYPE_W'($urandom);
    while (kind == TYPE_DATA || kind == TYPE_CONFIG || kind == TYPE_RULE);
    return kind;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_header(16'd0, TYPE_DATA, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    send_header(16'd6, TYPE_RULE, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_header(16'd7, TYPE_DATA, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_header(16'd13, TYPE_RULE, 16'h1111, 16'h2222, 8'h33, 16'h4444);
    send_header(16'd14, TYPE_RULE, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    send_header(16'hFFFF, TYPE_RULE, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_header(16'd7, TYPE_DATA, 16'h0000, 16'h0000, 8'hA5, 16'h5A5A);
    send_header(16'hFFFF, TYPE_DATA, 16'hFFFF, 16'hFFFF, 8'h00, 16'h0000);
    send_header(16'd20, TYPE_DATA, 16'hFFFF, 16'h0000, 8'h00, 16'h0000);
    send_header(16'd20, TYPE_DATA, 16'h0000, 16'hFFFF, 8'h00, 16'h0000);
    send_header(16'd14, TYPE_RULE, 16'h0000, 16'h0000, 8'h5A, 16'h1234);
    send_header(16'd30, TYPE_DATA, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    send_header(16'd14, TYPE_RULE, 16'hBEEF, 16'hCAFE, 8'h81, 16'h8001);
    send_header(16'd15, TYPE_DATA, 16'hBEEF, 16'hCAFE, 8'h00, 16'h0000);
    send_header(16'd7, TYPE_CONFIG, 16'h1234, 16'h5678, 8'h9A, 16'hBCDE);
    send_header(16'd6, TYPE_CONFIG, 16'h1234, 16'h5678, 8'h9A, 16'hBCDE);
    send_header(16'd5, TYPE_DATA, 16'hBEEF, 16'hCAFE, 8'h00, 16'h0000);
    send_header(16'd40, 8'h00, 16'h0001, 16'h0002, 8'h03, 16'h0004);
    send_header(16'd40, 8'hFF, 16'h0001, 16'h0002, 8'h03, 16'h0004);
    send_header(16'd40, 8'h11, 16'h0001, 16'h0002, 8'h03, 16'h0004);
    send_header(16'd40, 8'h13, 16'h0001, 16'h0002, 8'h03, 16'h0004);

    repeat (RANDOM_PER_PHASE) send_random_header();
    send_idle_pct = 84;
    recv_idle_pct = 38;
    repeat (RANDOM_PER_PHASE) send_random_header();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_header();

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (4 * (DEFAULT_TABLE_DEPTH + 3)) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
